@@ design/mfk_pkg.sv @@
package mfk_pkg;

    localparam int unsigned ANGLE_TABLE_BITS_DEF = 10;
    localparam int unsigned PIPE_STAGES          = 5;
    localparam int unsigned UNIT_W               = 16;
    localparam int unsigned TRIG_W               = UNIT_W + 1;
    localparam int unsigned CFG_INDEX_W          = 2;
    localparam int unsigned CFG_DATA_W           = 24;
    localparam logic [15:0] PHASE_OFFSET         = 16'd8192;
    localparam longint unsigned PI_Q30           = 64'd3373259426;

    localparam logic [CFG_INDEX_W-1:0] CFG_WHEEL_SCALE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_YAW_GAIN    = 2'd1;

    typedef struct packed {
        logic signed [31:0] wheel_one_speed;
        logic signed [31:0] wheel_two_speed;
        logic signed [31:0] wheel_three_speed;
        logic signed [31:0] wheel_four_speed;
        logic        [15:0] heading;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] yaw_rate;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic [PIPE_STAGES-1:0] valid;
    } t_pipe_ctrl;

    // unsigned quotient by shift and subtract; elaboration only
    function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quadrant sine/cosine in Q1.15, {sin, cos}; evaluated at elaboration only.
    function automatic logic [2*UNIT_W-1:0] quad_sincos(input logic [13:0] x);
        longint unsigned rad;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint          ss;
        longint          sc;
        longint          sn;
        longint          cn;
        rad = (longint'(x) * PI_Q30) >> 15;
        x2  = (rad * rad) >> 30;
        ts  = rad;
        tc  = 64'd1 << 30;
        ss  = longint'(rad);
        sc  = longint'(tc);
        for (int k = 1; k <= 10; k++) begin
            ts = udiv_u64((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = udiv_u64((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if (k[0] == 1'b1) begin
                ss = ss - longint'(ts);
                sc = sc - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                sc = sc + longint'(tc);
            end
        end
        if (ss < 0) ss = 0;
        if (sc < 0) sc = 0;
        if (ss > (64'sd1 << 30)) ss = 64'sd1 << 30;
        if (sc > (64'sd1 << 30)) sc = 64'sd1 << 30;
        sn = (ss + (64'sd1 << 14)) >>> 15;
        cn = (sc + (64'sd1 << 14)) >>> 15;
        return {sn[UNIT_W-1:0], cn[UNIT_W-1:0]};
    endfunction

    // {clipped flag, value clipped to signed 32 bits}
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

@@ design/mfk_ctrl.sv @@
module mfk_ctrl import mfk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output t_pipe_ctrl o_ctrl
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] en;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        en[PIPE_STAGES-1] = !r_valid[PIPE_STAGES-1] || i_out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (en[0]) n_valid[0] = i_in_valid;
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (en[k]) n_valid[k] = r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready   = en[0];
    assign o_ctrl.en    = en;
    assign o_ctrl.valid = r_valid;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_valid[0])
        else $error("accepted item missing from first stage");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[PIPE_STAGES-1] |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_stalled_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[2] && !en[3]) |=> r_valid[2])
        else $error("stalled item dropped in mid pipeline");
`endif

endmodule

@@ design/mfk_sincos.sv @@
module mfk_sincos import mfk_pkg::*; #(
    parameter int unsigned ANGLE_TABLE_BITS = ANGLE_TABLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [15:0]              i_heading,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    localparam int unsigned IDX_W = ANGLE_TABLE_BITS - 2;
    localparam int unsigned DROP  = 16 - ANGLE_TABLE_BITS;
    localparam int unsigned DEPTH = 1 << IDX_W;

    typedef logic [2*UNIT_W-1:0] t_rom [DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < DEPTH; i++) begin
            rom[i] = quad_sincos(14'(i << DROP));
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [15:0]              phase;
    logic [1:0]               quad;
    logic [IDX_W-1:0]         idx;
    logic [2*UNIT_W-1:0]      entry;
    logic signed [TRIG_W-1:0] a;
    logic signed [TRIG_W-1:0] b;
    logic signed [TRIG_W-1:0] n_sin;
    logic signed [TRIG_W-1:0] n_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;

    assign phase = i_heading + PHASE_OFFSET;
    assign quad  = phase[15:14];
    assign idx   = phase[13:DROP];
    assign entry = ROM[idx];
    assign a     = signed'({1'b0, entry[2*UNIT_W-1:UNIT_W]});
    assign b     = signed'({1'b0, entry[UNIT_W-1:0]});

    always_comb begin
        case (quad)
            2'd0: begin
                n_sin = a;
                n_cos = b;
            end
            2'd1: begin
                n_sin = b;
                n_cos = -a;
            end
            2'd2: begin
                n_sin = -a;
                n_cos = -b;
            end
            default: begin
                n_sin = -b;
                n_cos = a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

@@ design/mfk_body.sv @@
module mfk_body import mfk_pkg::*; (
    input  logic                     i_clk,
    input  t_pipe_ctrl               i_ctrl,
    input  t_in_item                 i_item,
    input  logic signed [TRIG_W-1:0] i_sin,
    input  logic signed [TRIG_W-1:0] i_cos,
    input  logic [15:0]              i_wheel_scale,
    input  logic [23:0]              i_yaw_gain,
    output t_out_item                o_item
);

    // stage 1: wheel differences and sum
    logic signed [32:0] n1_d13, n1_d24, r1_d13, r1_d24;
    logic signed [33:0] n1_sum, r1_sum;
    // stage 2: rotation and yaw products
    logic signed [49:0] n2_sd13, n2_cd24, n2_cd13, n2_sd24;
    logic signed [49:0] r2_sd13, r2_cd24, r2_cd13, r2_sd24;
    logic signed [58:0] n2_pw, r2_pw;
    // stage 3: rotation rounded to Q16.16, yaw finished
    logic signed [50:0] n3_xs, n3_ys;
    logic signed [35:0] n3_tx, n3_ty, r3_tx, r3_ty;
    logic signed [59:0] n3_ws;
    logic signed [43:0] n3_wr;
    logic [32:0]        n3_wsat;
    logic signed [31:0] r3_vw, r4_vw;
    logic               r3_sat, r4_sat;
    // stage 4: scale products
    logic signed [52:0] n4_mx, n4_my, r4_mx, r4_my;
    // stage 5: rounding and clipping into the output register
    logic signed [53:0] n5_xs, n5_ys;
    logic signed [37:0] n5_xr, n5_yr;
    logic [32:0]        n5_xsat, n5_ysat;
    t_out_item          n5_item, r5_item;

    always_comb begin
        n1_d13 = 33'(i_item.wheel_one_speed) - 33'(i_item.wheel_three_speed);
        n1_d24 = 33'(i_item.wheel_two_speed) - 33'(i_item.wheel_four_speed);
        n1_sum = 34'(i_item.wheel_one_speed) + 34'(i_item.wheel_two_speed)
               + 34'(i_item.wheel_three_speed) + 34'(i_item.wheel_four_speed);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r1_d13 <= n1_d13;
            r1_d24 <= n1_d24;
            r1_sum <= n1_sum;
        end
    end

    always_comb begin
        n2_sd13 = r1_d13 * i_sin;
        n2_cd24 = r1_d24 * i_cos;
        n2_cd13 = r1_d13 * i_cos;
        n2_sd24 = r1_d24 * i_sin;
        n2_pw   = r1_sum * signed'({1'b0, i_yaw_gain});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r2_sd13 <= n2_sd13;
            r2_cd24 <= n2_cd24;
            r2_cd13 <= n2_cd13;
            r2_sd24 <= n2_sd24;
            r2_pw   <= n2_pw;
        end
    end

    always_comb begin
        n3_xs   = 51'(r2_sd13) - 51'(r2_cd24) + 51'sd16384;
        n3_ys   = 51'(r2_cd13) + 51'(r2_sd24) + 51'sd16384;
        n3_tx   = n3_xs[50:15];
        n3_ty   = n3_ys[50:15];
        n3_ws   = 60'(r2_pw) + 60'sd32768;
        n3_wr   = n3_ws[59:16];
        n3_wsat = sat32(64'(n3_wr));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[2]) begin
            r3_tx  <= n3_tx;
            r3_ty  <= n3_ty;
            r3_vw  <= n3_wsat[31:0];
            r3_sat <= n3_wsat[32];
        end
    end

    always_comb begin
        n4_mx = r3_tx * signed'({1'b0, i_wheel_scale});
        n4_my = r3_ty * signed'({1'b0, i_wheel_scale});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[3]) begin
            r4_mx  <= n4_mx;
            r4_my  <= n4_my;
            r4_vw  <= r3_vw;
            r4_sat <= r3_sat;
        end
    end

    always_comb begin
        n5_xs   = 54'(r4_mx) + 54'sd32768;
        n5_ys   = 54'(r4_my) + 54'sd32768;
        n5_xr   = n5_xs[53:16];
        n5_yr   = n5_ys[53:16];
        n5_xsat = sat32(64'(n5_xr));
        n5_ysat = sat32(64'(n5_yr));
        n5_item.velocity_x = n5_xsat[31:0];
        n5_item.velocity_y = n5_ysat[31:0];
        n5_item.yaw_rate   = r4_vw;
        n5_item.saturated  = n5_xsat[32] | n5_ysat[32] | r4_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[4]) begin
            r5_item <= n5_item;
        end
    end

    assign o_item = r5_item;

endmodule

@@ design/mecanum_forward_kinematics_unit.sv @@
// Mecanum forward kinematics: four Q16.16 wheel speeds and a binary-angle heading in, world-frame
// velocity_x, velocity_y and yaw_rate (Q16.16, clipped, with a saturated flag) out. Five register
// stages, the last one being the output register; one item is taken per cycle while o_in_ready is
// high. Heading is quantized to ANGLE_TABLE_BITS bits and looked up in a quarter-wave sine/cosine
// ROM of 2^(ANGLE_TABLE_BITS-2) entries built at elaboration. Each full stage holds while the stage
// after it cannot load, so a stalled output costs no throughput until the pipeline fills. Write
// wheel_scale (index 0) and yaw_gain (index 1) only while no item is in flight.
module mecanum_forward_kinematics_unit import mfk_pkg::*; #(
    parameter int unsigned ANGLE_TABLE_BITS = ANGLE_TABLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [15:0]              r_wheel_scale;
    logic [23:0]              r_yaw_gain;
    t_pipe_ctrl               w_ctrl;
    logic signed [TRIG_W-1:0] w_sin;
    logic signed [TRIG_W-1:0] w_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_scale <= '0;
            r_yaw_gain    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WHEEL_SCALE: r_wheel_scale <= i_cfg_data[15:0];
                CFG_YAW_GAIN:    r_yaw_gain    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    mfk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_ctrl      (w_ctrl)
    );

    mfk_sincos #(
        .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS)
    ) u_sincos (
        .i_clk     (i_clk),
        .i_en      (w_ctrl.en[0]),
        .i_heading (i_in_item.heading),
        .o_sin     (w_sin),
        .o_cos     (w_cos)
    );

    mfk_body u_body (
        .i_clk         (i_clk),
        .i_ctrl        (w_ctrl),
        .i_item        (i_in_item),
        .i_sin         (w_sin),
        .i_cos         (w_cos),
        .i_wheel_scale (r_wheel_scale),
        .i_yaw_gain    (r_yaw_gain),
        .o_item        (o_out_item)
    );

    assign o_out_valid = w_ctrl.valid[PIPE_STAGES-1];

endmodule
